>>> design/b58e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b58e_pkg
// Shared types, constants and the digit-to-character mapping of the
// base-58 encoder.
// ----------------------------------------------------------------------------
package b58e_pkg;

    // Width of the input value field and of the output character field.
    localparam int VALUE_W       = 64;
    localparam int CHAR_W        = 7;
    localparam int DIGIT_W       = 6;
    localparam int DEF_VALUE_BITS = 64;

    // Radix and the threshold at which doubling a digit carries out.
    localparam logic [DIGIT_W:0]   RADIX     = 7'd58;
    localparam logic [DIGIT_W-1:0] HALF_RADIX = 6'd29;

    // Number of base-58 digits needed for a value of vb bits
    // (log2 of 58 is a little under 5.858).
    function automatic int num_digits(input int vb);
        return (vb * 1000 + 5857) / 5858;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take a new value and clear the digits
        logic shift;      // shift one value bit into the digit cells
        logic start_out;  // point at the most significant non-zero digit
        logic next;       // step to the next lower digit
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_last;    // the digit being shown is the least significant
    } status_t;

    // Alphabet without 0, O, I and l: digits, lower case, then upper case.
    function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dd;
        dd = {1'b0, d};
        if (d < 6'd9)
            return 7'h31 + dd;              // '1' .. '9'
        else if (d < 6'd20)
            return 7'h61 + (dd - 7'd9);     // 'a' .. 'k'
        else if (d < 6'd34)
            return 7'h6D + (dd - 7'd20);    // 'm' .. 'z'
        else if (d < 6'd42)
            return 7'h41 + (dd - 7'd34);    // 'A' .. 'H'
        else if (d < 6'd47)
            return 7'h4A + (dd - 7'd42);    // 'J' .. 'N'
        else if (d < 6'd58)
            return 7'h50 + (dd - 7'd47);    // 'P' .. 'Z'
        else
            return 7'h31;
    endfunction

endpackage

>>> design/base58_encode_u64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base58_encode_u64
// Converts an unsigned identifier to base-58 text, one character per output handshake.
// ----------------------------------------------------------------------------
// Input channel: value with in_valid / in_ready. Only the low VALUE_BITS
// bits of value are converted.
// Output channel: digit_char (ASCII) and last_digit with out_valid /
// out_ready, most significant digit first, leading zeros dropped; zero
// gives the single character '1', and last_digit marks the final character.
// One item is handled at a time. After acceptance the value is shifted one
// bit per cycle into a row of base-58 digit cells, the select state then
// locates the top digit, and the first character is offered on the
// following cycle.
// in_ready is high only while the block is idle.
// When the receiver stalls, the current character and flag are held until
// taken. Reset returns the block to idle with no output pending.
// ----------------------------------------------------------------------------
module base58_encode_u64 #(
    parameter int VALUE_BITS = b58e_pkg::DEF_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [b58e_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [b58e_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last_digit
);
    import b58e_pkg::*;

    cmd_t    cmd;
    status_t status;

    b58e_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    b58e_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .digit_char (digit_char)
    );

    assign last_digit = status.at_last;

`ifndef ASSERT_OFF
    // The block never offers a character while it is ready for a new item.
    a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid high together");

    // An accepted item makes the block busy.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("block still ready after accepting an item");

    // Taking the final character returns the block to idle.
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_digit) |=> (in_ready && !out_valid))
        else $error("block not idle after the final character");

    // Taking any other character leaves another one on offer.
    a_more_after_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_digit) |=> out_valid)
        else $error("characters stopped before the final one");
`endif

endmodule

>>> design/b58e_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b58e_datapath
// Value shift register, a row of base-58 digit cells filled by doubling
// with carry, and the read pointer that walks the digits for output.
// ----------------------------------------------------------------------------
module b58e_datapath #(
    parameter int VALUE_BITS = b58e_pkg::DEF_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [b58e_pkg::VALUE_W-1:0]  value,
    input  b58e_pkg::cmd_t                cmd,
    output b58e_pkg::status_t             status,
    output logic [b58e_pkg::CHAR_W-1:0]   digit_char
);
    import b58e_pkg::*;

    localparam int NUM_DIGITS = num_digits(VALUE_BITS);
    localparam int PTR_W      = $clog2(NUM_DIGITS);

    logic [VALUE_BITS-1:0] value_reg;
    logic [DIGIT_W-1:0]    digit_reg  [NUM_DIGITS];
    logic [DIGIT_W-1:0]    digit_next [NUM_DIGITS];
    logic [PTR_W-1:0]      ptr_reg;
    logic [PTR_W-1:0]      top_idx;

    // Each cell doubles its digit and adds the carry of the cell below.
    // The carry of a cell depends only on its own old digit, so all cells
    // update in parallel.
    always_comb
    begin
        logic             cin;
        logic [DIGIT_W:0] t;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (i == 0)
                cin = value_reg[VALUE_BITS-1];
            else
                cin = (digit_reg[i-1] >= HALF_RADIX);
            t = {digit_reg[i], cin};
            if (t >= RADIX)
                digit_next[i] = DIGIT_W'(t - RADIX);
            else
                digit_next[i] = t[DIGIT_W-1:0];
        end
    end

    // Most significant non-zero digit; zero shows a single digit.
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (digit_reg[i] != '0)
                top_idx = PTR_W'(i);
        end
    end

    // Value and digit registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value[VALUE_BITS-1:0];
            for (int i = 0; i < NUM_DIGITS; i++)
                digit_reg[i] <= '0;
        end
        else if (cmd.shift)
        begin
            value_reg <= {value_reg[VALUE_BITS-2:0], 1'b0};
            for (int i = 0; i < NUM_DIGITS; i++)
                digit_reg[i] <= digit_next[i];
        end
    end

    // Output pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= '0;
        else if (cmd.start_out)
            ptr_reg <= top_idx;
        else if (cmd.next)
            ptr_reg <= ptr_reg - 1'b1;
    end

    assign digit_char     = b58_char(digit_reg[ptr_reg]);
    assign status.at_last = (ptr_reg == '0);

endmodule

>>> design/b58e_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b58e_ctrl
// Controller: accepts an item, sequences the bit-by-bit conversion and
// hands the characters out one per output handshake.
// ----------------------------------------------------------------------------
module b58e_ctrl #(
    parameter int VALUE_BITS = b58e_pkg::DEF_VALUE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  b58e_pkg::status_t status,
    output b58e_pkg::cmd_t    cmd
);
    import b58e_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SEL,
        ST_OUT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(VALUE_BITS);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_SEL;
            end
            ST_SEL:
            begin
                cmd.start_out = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (status.at_last)
                        state_next = ST_IDLE;
                    else
                        cmd.next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and bit counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
